>>> rtl/oas_pkg.sv
`timescale 1ns / 1ps

package oas_pkg;

	localparam int DistW    = 12;
	localparam int TimeW    = 32;
	localparam int MsW      = 16;
	localparam int DegW     = 8;
	localparam int HeadW    = 10;
	localparam int DirW     = 3;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;
	localparam int InDataW  = 56;
	localparam int OutDataW = 24;

	localparam logic [DistW-1:0] ClearDistRst = 12'd50;
	localparam logic [DistW-1:0] OpenDistRst  = 12'd100;
	localparam logic [MsW-1:0]   LookMsRst    = 16'd1200;
	localparam logic [MsW-1:0]   SettleMsRst  = 16'd2000;
	localparam logic [DegW-1:0]  TurnDegRst   = 8'd45;

	localparam logic [DegW-1:0] AngleLeftFront  = 8'd45;
	localparam logic [DegW-1:0] AngleRightFront = 8'd135;
	localparam logic [DegW-1:0] AngleRight      = 8'd180;
	localparam logic [DegW-1:0] AngleLeft       = 8'd0;
	localparam logic [DegW-1:0] AngleCenter     = 8'd90;

	typedef enum logic [3:0] {
		PH_ADVANCE    = 4'd0,
		PH_LOOK_1     = 4'd1,
		PH_LOOK_2     = 4'd2,
		PH_LOOK_3     = 4'd3,
		PH_LOOK_4     = 4'd4,
		PH_BACKUP     = 4'd5,
		PH_TURN_START = 4'd6,
		PH_TURN       = 4'd7,
		PH_SETTLE     = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		MOTOR_NONE    = 3'd0,
		MOTOR_ADVANCE = 3'd1,
		MOTOR_BACK    = 3'd2,
		MOTOR_LEFT    = 3'd3,
		MOTOR_RIGHT   = 3'd4,
		MOTOR_STOP    = 3'd5
	} motor_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_CLEAR_DIST = 3'd0,
		CFG_OPEN_DIST  = 3'd1,
		CFG_LOOK_MS    = 3'd2,
		CFG_SETTLE_MS  = 3'd3,
		CFG_TURN_DEG   = 3'd4
	} cfg_idx_t;

	localparam logic signed [DirW-1:0] DirLeftFront  = 3'sd1;
	localparam logic signed [DirW-1:0] DirRightFront = -3'sd1;
	localparam logic signed [DirW-1:0] DirRight      = -3'sd2;
	localparam logic signed [DirW-1:0] DirLeft       = 3'sd2;

	typedef struct packed {
		logic [DistW-1:0] clear_dist;
		logic [DistW-1:0] open_dist;
		logic [MsW-1:0]   look_ms;
		logic [MsW-1:0]   settle_ms;
		logic [DegW-1:0]  turn_deg;
	} cfg_t;

	typedef struct packed {
		logic [3:0]              phase;
		logic [TimeW-1:0]        phase_start;
		logic signed [DirW-1:0]  turn_dir;
	} seq_state_t;

	typedef struct packed {
		logic [TimeW-1:0]        time_ms;
		logic [DistW-1:0]        obstacle_dist;
		logic signed [HeadW-1:0] heading;
		logic                    restart;
	} tick_t;

	typedef struct packed {
		motor_t          motor_cmd;
		logic            servo_valid;
		logic [DegW-1:0] servo_angle;
		logic            clear_heading;
		logic [3:0]      phase_out;
	} result_t;

endpackage

>>> rtl/oas_step.sv
`timescale 1ns / 1ps

module oas_step import oas_pkg::*; (
	input  cfg_t       cfg,
	input  seq_state_t cur,
	input  tick_t      tick,
	output seq_state_t nxt,
	output result_t    res
);

	logic [TimeW-1:0]       elapsed;
	logic [MsW-1:0]         limit;
	logic                   waited;
	logic                   open_path;
	logic signed [11:0]     target;
	logic signed [11:0]     head_ext;
	logic                   turn_done;

	// Only one wait is ever running, so a single subtractor serves all phases.
	assign elapsed   = tick.time_ms - cur.phase_start;
	assign limit     = (cur.phase == PH_SETTLE) ? cfg.settle_ms : cfg.look_ms;
	assign waited    = elapsed > {{(TimeW-MsW){1'b0}}, limit};
	assign open_path = tick.obstacle_dist > cfg.open_dist;
	assign target    = $signed({4'd0, cfg.turn_deg})
		* $signed({{(12-DirW){cur.turn_dir[DirW-1]}}, cur.turn_dir});
	assign head_ext  = {{2{tick.heading[HeadW-1]}}, tick.heading};
	assign turn_done = (!cur.turn_dir[DirW-1] && (cur.turn_dir != '0) && (head_ext >= target))
		|| (cur.turn_dir[DirW-1] && (head_ext <= target));

	always_comb begin
		nxt               = cur;
		res.motor_cmd     = MOTOR_NONE;
		res.servo_valid   = 1'b0;
		res.servo_angle   = '0;
		res.clear_heading = 1'b0;

		if (tick.restart) begin
			nxt.phase       = PH_ADVANCE;
			nxt.phase_start = tick.time_ms;
			res.servo_valid = 1'b1;
			res.servo_angle = AngleCenter;
		end else begin
			unique case (cur.phase)
				PH_ADVANCE: begin
					if (tick.obstacle_dist > cfg.clear_dist) begin
						res.motor_cmd = MOTOR_ADVANCE;
					end else begin
						res.motor_cmd   = MOTOR_STOP;
						nxt.phase       = PH_LOOK_1;
						nxt.phase_start = tick.time_ms;
					end
				end
				PH_LOOK_1, PH_LOOK_2, PH_LOOK_3, PH_LOOK_4: begin
					res.servo_valid = 1'b1;
					unique case (cur.phase)
						PH_LOOK_1: res.servo_angle = AngleLeftFront;
						PH_LOOK_2: res.servo_angle = AngleRightFront;
						PH_LOOK_3: res.servo_angle = AngleRight;
						default:   res.servo_angle = AngleLeft;
					endcase
					if (waited) begin
						if (open_path) begin
							nxt.phase = PH_TURN_START;
							unique case (cur.phase)
								PH_LOOK_1: nxt.turn_dir = DirLeftFront;
								PH_LOOK_2: nxt.turn_dir = DirRightFront;
								PH_LOOK_3: nxt.turn_dir = DirRight;
								default:   nxt.turn_dir = DirLeft;
							endcase
						end else begin
							nxt.phase       = cur.phase + 4'd1;
							nxt.phase_start = tick.time_ms;
						end
					end
				end
				PH_BACKUP: begin
					res.motor_cmd = MOTOR_BACK;
					if (waited) begin
						res.motor_cmd   = MOTOR_STOP;
						nxt.phase       = PH_LOOK_1;
						nxt.phase_start = tick.time_ms;
					end
				end
				PH_TURN_START: begin
					res.clear_heading = 1'b1;
					res.motor_cmd     = (!cur.turn_dir[DirW-1] && (cur.turn_dir != '0))
						? MOTOR_RIGHT : MOTOR_LEFT;
					nxt.phase         = PH_TURN;
				end
				PH_TURN: begin
					if (turn_done) begin
						res.servo_valid = 1'b1;
						res.servo_angle = AngleCenter;
						res.motor_cmd   = MOTOR_STOP;
						nxt.phase_start = tick.time_ms;
						nxt.phase       = PH_SETTLE;
					end
				end
				PH_SETTLE: begin
					if (waited) begin
						res.servo_valid = 1'b1;
						res.servo_angle = AngleCenter;
						nxt.phase       = PH_ADVANCE;
					end
				end
				// Phases above settle are unreachable; hold until restart.
				default: begin
				end
			endcase
		end
		res.phase_out = nxt.phase;
	end

endmodule

>>> rtl/obstacle_avoid_sequencer_unit.sv
`timescale 1ns / 1ps
// Path: an accepted word is held in one input register, then in one result register,
// before it is presented on the output.
// Throughput: one word per cycle while the output is not stalled; the phase, its start time
// and the turn direction are updated in the same cycle as the result register is loaded.
// Reset (arst_n low, asynchronous): phase 0, start time 0, turn direction 0,
// configuration registers to their defaults, both pipeline slots empty.
module obstacle_avoid_sequencer_unit import oas_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// time_ms[31:0], obstacle_dist[43:32], heading[53:44], restart[54], zero[55]
	input  logic [InDataW-1:0]  s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// motor_cmd[2:0], servo_valid[3], servo_angle[11:4], clear_heading[12],
	// phase_out[16:13], zero[23:17]
	output logic [OutDataW-1:0] m_axis_tdata,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t       cfg_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	tick_t      tick_s1;
	logic       valid_s1;
	result_t    res_s1;
	result_t    res_q;
	logic       out_valid_q;
	logic       load;

	assign load          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || load;

	oas_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.tick (tick_s1),
		.nxt  (state_nxt),
		.res  (res_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clear_dist <= ClearDistRst;
			cfg_q.open_dist  <= OpenDistRst;
			cfg_q.look_ms    <= LookMsRst;
			cfg_q.settle_ms  <= SettleMsRst;
			cfg_q.turn_deg   <= TurnDegRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLEAR_DIST: cfg_q.clear_dist <= cfg_data[DistW-1:0];
				CFG_OPEN_DIST:  cfg_q.open_dist  <= cfg_data[DistW-1:0];
				CFG_LOOK_MS:    cfg_q.look_ms    <= cfg_data[MsW-1:0];
				CFG_SETTLE_MS:  cfg_q.settle_ms  <= cfg_data[MsW-1:0];
				CFG_TURN_DEG:   cfg_q.turn_deg   <= cfg_data[DegW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (load) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			tick_s1.time_ms       <= s_axis_tdata[31:0];
			tick_s1.obstacle_dist <= s_axis_tdata[43:32];
			tick_s1.heading       <= s_axis_tdata[53:44];
			tick_s1.restart       <= s_axis_tdata[54];
		end
		if (load) begin
			res_q <= res_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, res_q.phase_out, res_q.clear_heading, res_q.servo_angle,
		res_q.servo_valid, res_q.motor_cmd};

`ifndef SYNTHESIS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase <= PH_SETTLE)
		else $error("sequence phase left the defined range");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		($signed(state_q.turn_dir) >= -3'sd2) && ($signed(state_q.turn_dir) <= 3'sd2))
		else $error("turn direction outside -2..2");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> $stable(state_q))
		else $error("sequencer state changed without a result being loaded");

	a_turn_follows: assert property (@(posedge clk) disable iff (!arst_n)
		load && !tick_s1.restart && (state_q.phase == PH_TURN_START)
		|=> state_q.phase == PH_TURN)
		else $error("turn start did not advance to turning");

	a_result_phase: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> res_q.phase_out == state_q.phase)
		else $error("reported phase differs from the stored phase");
`endif

endmodule
